// File: design/fwq_pkg.sv
package fwq_pkg;

    localparam int NUM_THREADS = 16;
    localparam int ID_W        = 4;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_TAKE    = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_REMOVE  = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_QUEUED    = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_SHIFT  = 3'd2,
        OP_MARK   = 3'd3,
        OP_BUBBLE = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t        op;
        logic [ID_W-1:0] id;
    } cell_cmd_t;

    typedef struct packed {
        logic            valid;
        logic            hole;
        logic [ID_W-1:0] id;
    } cell_state_t;

endpackage

// File: design/fwq_cell.sv
module fwq_cell
    import fwq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_cmd_t   cmd,
    input  logic        left_valid,
    input  logic        left_hole,
    input  cell_state_t right,
    output cell_state_t slot
);

    logic            valid_reg, valid_next;
    logic            hole_reg, hole_next;
    logic [ID_W-1:0] id_reg, id_next;

    always_comb
    begin
        valid_next = valid_reg;
        hole_next  = hole_reg;
        id_next    = id_reg;
        case (cmd.op)
            OP_HOLD:
            begin
            end
            OP_LOAD:
            begin
                // take the new item at the first free place
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    id_next    = cmd.id;
                end
            end
            OP_SHIFT:
            begin
                valid_next = right.valid;
                hole_next  = 1'b0;
                id_next    = right.id;
            end
            OP_MARK:
            begin
                if (valid_reg && (id_reg == cmd.id))
                begin
                    valid_next = 1'b0;
                    hole_next  = 1'b1;
                end
            end
            OP_BUBBLE:
            begin
                // fill the hole from the right, pass the hole on
                if (hole_reg)
                begin
                    valid_next = right.valid;
                    hole_next  = 1'b0;
                    id_next    = right.id;
                end
                else if (left_hole)
                begin
                    hole_next  = valid_reg;
                    valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hole_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hole_reg  <= hole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign slot = '{valid: valid_reg, hole: hole_reg, id: id_reg};

endmodule

// File: design/fifo_wait_queue_with_removal_core.sv
// FIFO wait queue of thread numbers, kept as a row of cells with the oldest
// waiter in cell 0. Requests arrive as items on the s_ side (kind in s_tuser,
// thread number in s_tdata) and results leave through a single output
// register on the m_ side. Enqueue, take-head and every rejected request are
// answered when accepted. Remove answers when accepted and then moves the freed
// place to the end of the row one cell per cycle, keeping the input closed
// meanwhile. Release-all detaches the chain and then drains it, each waiter
// leaving as its own item, oldest first, with m_tlast on the final one; output
// stalls hold up the drain. There is no clearing pass after reset; the queue
// is empty at once.
module fifo_wait_queue_with_removal_core
    import fwq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [3:0] thread_id, [7:4] zero
    input  logic [1:0] s_tuser,   // [1:0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] thread_out, [7:4] zero
    output logic       m_tlast,   // last
    output logic [2:0] m_tuser    // [1:0] status, [2] queue_empty
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_RELEASE = 3'b010,
        ST_BUBBLE  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [NUM_THREADS-1:0] in_queue_reg, in_queue_next;

    logic            out_valid_reg, out_valid_next;
    logic [ID_W-1:0] out_thread_reg, out_thread_next;
    status_t         out_status_reg, out_status_next;
    logic            out_last_reg, out_last_next;
    logic            out_empty_reg, out_empty_next;

    cell_cmd_t   cmd;
    cell_state_t cells [NUM_THREADS];

    logic [NUM_THREADS-1:0] valid_vec;
    logic [NUM_THREADS-1:0] hole_vec;
    logic [NUM_THREADS-1:0] id_sel;
    logic [NUM_THREADS-1:0] head_sel;

    logic            can_emit;
    logic            accept;
    logic            emit;
    req_t            req;
    logic [ID_W-1:0] req_id;
    logic            id_ok;
    logic            id_hit;
    logic            queue_live;

    // ------------------------------------------------------------------
    // Row of cells
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NUM_THREADS; g++)
    begin : g_cell
        logic        lv;
        logic        lh;
        cell_state_t rs;

        if (g == 0)
        begin : g_first
            assign lv = 1'b1;
            assign lh = 1'b0;
        end
        else
        begin : g_mid
            assign lv = cells[g-1].valid;
            assign lh = cells[g-1].hole;
        end

        if (g == NUM_THREADS - 1)
        begin : g_end
            assign rs = '0;
        end
        else
        begin : g_inner
            assign rs = cells[g+1];
        end

        fwq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_valid (lv),
            .left_hole  (lh),
            .right      (rs),
            .slot       (cells[g])
        );

        assign valid_vec[g] = cells[g].valid;
        assign hole_vec[g]  = cells[g].hole;
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign req        = req_t'(s_tuser);
    assign req_id     = s_tdata[ID_W-1:0];
    assign id_ok      = int'(req_id) < NUM_THREADS;
    assign queue_live = cells[0].valid;

    always_comb
    begin
        for (int i = 0; i < NUM_THREADS; i++)
        begin
            id_sel[i]   = int'(req_id) == i;
            head_sel[i] = int'(cells[0].id) == i;
        end
    end

    assign id_hit   = |(in_queue_reg & id_sel);
    assign can_emit = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && can_emit;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next      = state_reg;
        in_queue_next   = in_queue_reg;
        cmd.op          = OP_HOLD;
        cmd.id          = req_id;
        emit            = 1'b0;
        out_thread_next = out_thread_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    emit            = 1'b1;
                    out_thread_next = '0;
                    out_status_next = STAT_OK;
                    out_last_next   = 1'b1;
                    out_empty_next  = !queue_live;
                    case (req)
                        REQ_ENQUEUE:
                        begin
                            if (!id_ok)
                                out_status_next = STAT_NOT_FOUND;
                            else if (id_hit)
                                out_status_next = STAT_QUEUED;
                            else
                            begin
                                cmd.op         = OP_LOAD;
                                in_queue_next  = in_queue_reg | id_sel;
                                out_empty_next = 1'b0;
                            end
                        end
                        REQ_TAKE:
                        begin
                            if (!queue_live)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                cmd.op          = OP_SHIFT;
                                in_queue_next   = in_queue_reg & ~head_sel;
                                out_thread_next = cells[0].id;
                                out_empty_next  = !cells[1].valid;
                            end
                        end
                        REQ_RELEASE:
                        begin
                            if (!queue_live)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                // detach the chain now, drain it next
                                emit          = 1'b0;
                                in_queue_next = '0;
                                state_next    = ST_RELEASE;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!id_ok || !id_hit || !queue_live)
                                out_status_next = STAT_NOT_FOUND;
                            else
                            begin
                                cmd.op          = OP_MARK;
                                in_queue_next   = in_queue_reg & ~id_sel;
                                out_thread_next = req_id;
                                out_empty_next  = (in_queue_reg & ~id_sel) == '0;
                                state_next      = ST_BUBBLE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RELEASE:
            begin
                // emit the head and advance the row
                if (can_emit)
                begin
                    emit            = 1'b1;
                    cmd.op          = OP_SHIFT;
                    out_thread_next = cells[0].id;
                    out_status_next = STAT_OK;
                    out_last_next   = !cells[1].valid;
                    out_empty_next  = 1'b1;
                    if (!cells[1].valid)
                        state_next = ST_IDLE;
                end
            end
            ST_BUBBLE:
            begin
                // move the freed place toward the end of the row
                cmd.op = OP_BUBBLE;
                if (hole_vec == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_queue_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_queue_reg  <= in_queue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_thread_reg <= out_thread_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
            out_empty_reg  <= out_empty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - ID_W){1'b0}}, out_thread_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_empty_reg, out_status_reg};

`ifndef SYNTH
    // Idle row holds as many valid cells as there are queued threads
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_vec) == $countones(in_queue_reg)))
        else $error("cell row and membership bits disagree");

    // Idle row holds no hole
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (hole_vec == '0))
        else $error("hole left in idle row");

    // At most one hole travels along the row
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(hole_vec) <= 1)
        else $error("more than one hole in row");

    // A drain never runs on an empty row
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELEASE) |-> cells[0].valid)
        else $error("release drain on empty row");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench
    import fwq_pkg::*;
();

    // One result item as the queue reports it
    typedef struct packed {
        logic [ID_W-1:0] thr;
        status_t         st;
        logic            lst;
        logic            emp;
    } wq_result_t;

    // One request item waiting to be driven
    typedef struct packed {
        req_t            kind;
        logic [ID_W-1:0] id;
    } wq_request_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [3:0] thread_id, [7:4] zero
    logic [1:0] s_tuser;   // [1:0] req_type
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [3:0] thread_out, [7:4] zero
    logic       m_tlast;   // last
    logic [2:0] m_tuser;   // [1:0] status, [2] queue_empty

    fifo_wait_queue_with_removal_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Requests still to be driven, and results still owed by the block
    wq_request_t request_queue[$];
    wq_result_t  due_results[$];

    // Shadow of the line as the stimulus plans it, used only to pick ids
    int planned_line[$];

    // Predicted queue contents
    logic [ID_W-1:0] wait_link [NUM_THREADS];
    bit              is_waiting[NUM_THREADS];
    logic [ID_W-1:0] head_thr;
    logic [ID_W-1:0] tail_thr;
    bit              has_waiters;

    int  sent_items;
    int  total_items;
    int  fail_count;
    bit  req_taken;
    bit  calm;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // No idling on either side while this window of items goes through
    assign calm = (sent_items >= 60) && (sent_items < 110);

    function automatic void note_fail(input string msg);
        if (fail_count < 10)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    function automatic void push_result(input logic [ID_W-1:0] thr, input status_t st,
                                        input logic lst, input logic emp);
        wq_result_t r;
        r.thr = thr;
        r.st  = st;
        r.lst = lst;
        r.emp = emp;
        due_results.push_back(r);
    endfunction

    // Advance the predicted queue by one request and queue the results it owes
    task automatic predict_request(input req_t kind, input logic [ID_W-1:0] id);
        logic [ID_W-1:0] cur;
        logic [ID_W-1:0] prev;
        logic [ID_W-1:0] nxt;
        logic [ID_W-1:0] tl;
        bit              have_prev;
        bit              fin;
        bit              found;
        bit              stop;
        bit              is_tail;
        int              steps;
        case (kind)
            REQ_ENQUEUE:
            begin
                if (int'(id) >= NUM_THREADS)
                begin
                    push_result('0, STAT_NOT_FOUND, 1'b1, !has_waiters);
                end
                else if (is_waiting[id])
                begin
                    push_result('0, STAT_QUEUED, 1'b1, !has_waiters);
                end
                else
                begin
                    wait_link[id]  = '0;
                    is_waiting[id] = 1'b1;
                    if (has_waiters)
                    begin
                        wait_link[tail_thr] = id;
                    end
                    else
                    begin
                        head_thr = id;
                    end
                    tail_thr    = id;
                    has_waiters = 1'b1;
                    push_result('0, STAT_OK, 1'b1, 1'b0);
                end
            end
            REQ_TAKE:
            begin
                if (!has_waiters)
                begin
                    push_result('0, STAT_EMPTY, 1'b1, 1'b1);
                end
                else
                begin
                    cur = head_thr;
                    if (cur == tail_thr)
                    begin
                        has_waiters = 1'b0;
                        head_thr    = '0;
                        tail_thr    = '0;
                    end
                    else
                    begin
                        head_thr = wait_link[cur];
                    end
                    is_waiting[cur] = 1'b0;
                    wait_link[cur]  = '0;
                    push_result(cur, STAT_OK, 1'b1, !has_waiters);
                end
            end
            REQ_RELEASE:
            begin
                if (!has_waiters)
                begin
                    push_result('0, STAT_EMPTY, 1'b1, 1'b1);
                end
                else
                begin
                    // Detach the chain at once, then emit it oldest first
                    cur         = head_thr;
                    tl          = tail_thr;
                    has_waiters = 1'b0;
                    head_thr    = '0;
                    tail_thr    = '0;
                    steps       = 0;
                    fin         = 1'b0;
                    while (!fin)
                    begin
                        nxt = wait_link[cur];
                        // The walk bound and the result bound are both sixteen
                        fin = (cur == tl) || (steps + 1 >= NUM_THREADS);
                        is_waiting[cur] = 1'b0;
                        wait_link[cur]  = '0;
                        push_result(cur, STAT_OK, fin, 1'b1);
                        steps++;
                        cur = nxt;
                    end
                    foreach (is_waiting[i])
                    begin
                        is_waiting[i] = 1'b0;
                    end
                end
            end
            default:
            begin
                found = 1'b0;
                if (int'(id) < NUM_THREADS && is_waiting[id] && has_waiters)
                begin
                    cur       = head_thr;
                    prev      = '0;
                    have_prev = 1'b0;
                    stop      = 1'b0;
                    steps     = 0;
                    while (!stop && steps < NUM_THREADS)
                    begin
                        if (cur == id)
                        begin
                            nxt     = wait_link[cur];
                            is_tail = (cur == tail_thr);
                            if (have_prev)
                            begin
                                wait_link[prev] = nxt;
                            end
                            else if (is_tail)
                            begin
                                has_waiters = 1'b0;
                                head_thr    = '0;
                            end
                            else
                            begin
                                head_thr = nxt;
                            end
                            if (is_tail)
                            begin
                                tail_thr = have_prev ? prev : '0;
                            end
                            is_waiting[id] = 1'b0;
                            wait_link[id]  = '0;
                            push_result(id, STAT_OK, 1'b1, !has_waiters);
                            found = 1'b1;
                            stop  = 1'b1;
                        end
                        else if (cur == tail_thr)
                        begin
                            stop = 1'b1;
                        end
                        else
                        begin
                            prev      = cur;
                            have_prev = 1'b1;
                            cur       = wait_link[cur];
                        end
                        steps++;
                    end
                end
                if (!found)
                begin
                    push_result('0, STAT_NOT_FOUND, 1'b1, !has_waiters);
                end
            end
        endcase
    endtask

    // Queue a request and keep the planning shadow in step with it
    task automatic add_request(input req_t kind, input int id);
        wq_request_t rq;
        int          pos;
        rq.kind = kind;
        rq.id   = id[ID_W-1:0];
        request_queue.push_back(rq);
        case (kind)
            REQ_ENQUEUE:
            begin
                pos = -1;
                foreach (planned_line[i])
                begin
                    if (planned_line[i] == id)
                    begin
                        pos = i;
                    end
                end
                if (pos < 0)
                begin
                    planned_line.push_back(id);
                end
            end
            REQ_TAKE:
            begin
                if (planned_line.size() > 0)
                begin
                    void'(planned_line.pop_front());
                end
            end
            REQ_RELEASE:
            begin
                planned_line.delete();
            end
            default:
            begin
                for (int i = planned_line.size() - 1; i >= 0; i--)
                begin
                    if (planned_line[i] == id)
                    begin
                        planned_line.delete(i);
                    end
                end
            end
        endcase
    endtask

    // Pick a random thread that the plan does not hold yet, or -1 when full
    function automatic int pick_free_thread();
        int pool[$];
        bit held[NUM_THREADS];
        foreach (planned_line[i])
        begin
            held[planned_line[i]] = 1'b1;
        end
        for (int t = 0; t < NUM_THREADS; t++)
        begin
            if (!held[t])
            begin
                pool.push_back(t);
            end
        end
        if (pool.size() == 0)
        begin
            return -1;
        end
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // Driver: take the item at the rising edge, present the next at the falling edge
    always @(posedge clk)
    begin
        req_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_request(req_t'(s_tuser), s_tdata[ID_W-1:0]);
            sent_items++;
        end
    end

    always @(negedge clk)
    begin
        wq_request_t rq;
        if (rst_n)
        begin
            // Hold an item that has not been taken yet
            if (!s_tvalid || req_taken)
            begin
                if (request_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 33))
                begin
                    rq = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0000, rq.id};
                    s_tuser  <= rq.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    // Monitor: compare each result item with the oldest one owed
    always @(posedge clk)
    begin
        wq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_results.size() == 0)
            begin
                note_fail($sformatf("unexpected result tdata=%0h tuser=%0h tlast=%0b",
                                    m_tdata, m_tuser, m_tlast));
            end
            else
            begin
                want = due_results.pop_front();
                if (m_tdata !== {4'b0000, want.thr} || m_tuser[1:0] !== want.st ||
                    m_tlast !== want.lst || m_tuser[2] !== want.emp)
                begin
                    note_fail($sformatf({"thread exp %0d got %0d, status exp %0d got %0d, ",
                                         "last exp %0b got %0b, empty exp %0b got %0b"},
                                        want.thr, m_tdata, want.st, m_tuser[1:0],
                                        want.lst, m_tlast, want.emp, m_tuser[2]));
                end
            end
        end
    end

    // Give up if the run hangs
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int roll;
        int free_thr;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_ENQUEUE;
        m_tready    = 1'b0;
        req_taken   = 1'b0;
        sent_items  = 0;
        fail_count  = 0;
        head_thr    = '0;
        tail_thr    = '0;
        has_waiters = 1'b0;
        foreach (wait_link[i])
        begin
            wait_link[i]  = '0;
            is_waiting[i] = 1'b0;
        end

        // Directed: empty-queue answers, duplicates, head, middle and tail removal
        add_request(REQ_TAKE, 15);
        add_request(REQ_RELEASE, 15);
        add_request(REQ_REMOVE, 0);
        add_request(REQ_ENQUEUE, 0);
        add_request(REQ_ENQUEUE, 0);
        add_request(REQ_ENQUEUE, 15);
        add_request(REQ_ENQUEUE, 5);
        add_request(REQ_TAKE, 0);
        add_request(REQ_REMOVE, 5);
        add_request(REQ_REMOVE, 15);
        add_request(REQ_REMOVE, 15);
        add_request(REQ_ENQUEUE, 3);
        add_request(REQ_ENQUEUE, 7);
        add_request(REQ_ENQUEUE, 9);
        add_request(REQ_REMOVE, 7);
        add_request(REQ_RELEASE, 0);

        // Random: fill the whole line once and release it, then mixed traffic
        free_thr = pick_free_thread();
        while (free_thr >= 0)
        begin
            add_request(REQ_ENQUEUE, free_thr);
            free_thr = pick_free_thread();
        end
        add_request(REQ_RELEASE, $urandom_range(0, 15));

        while (request_queue.size() < 160)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 38)
            begin
                free_thr = pick_free_thread();
                if (free_thr >= 0 && $urandom_range(0, 4) != 0)
                begin
                    add_request(REQ_ENQUEUE, free_thr);
                end
                else
                begin
                    add_request(REQ_ENQUEUE, $urandom_range(0, 15));
                end
            end
            else if (roll < 52)
            begin
                add_request(REQ_TAKE, $urandom_range(0, 15));
            end
            else if (roll < 72)
            begin
                if (planned_line.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    add_request(REQ_REMOVE,
                                planned_line[$urandom_range(0, planned_line.size() - 1)]);
                end
                else
                begin
                    add_request(REQ_REMOVE, $urandom_range(0, 15));
                end
            end
            else if (roll < 80)
            begin
                add_request(REQ_RELEASE, $urandom_range(0, 15));
            end
            else if (roll < 83)
            begin
                // Top the line up to full
                free_thr = pick_free_thread();
                while (free_thr >= 0)
                begin
                    add_request(REQ_ENQUEUE, free_thr);
                    free_thr = pick_free_thread();
                end
            end
            else
            begin
                add_request(req_t'($urandom_range(0, 3)), $urandom_range(0, 15));
            end
        end
        total_items = request_queue.size();

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        wait (sent_items == total_items);
        wait (due_results.size() == 0);
        // Let any stray result surface before the verdict
        repeat (4 * NUM_THREADS) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
